// ----- rtl/spath_pkg.sv -----
// Shared types and constants of the shortest path search core.
package spath_pkg;

   localparam int unsigned VERT_BITS     = 6;
   localparam int unsigned SLOT_BITS     = 3;
   localparam int unsigned WEIGHT_BITS   = 16;
   localparam int unsigned DIST_BITS     = 22;
   localparam int unsigned NUM_VERTS     = 64;
   localparam int unsigned NUM_SLOTS     = 8;
   localparam int unsigned ADJ_ADDR_BITS = VERT_BITS + SLOT_BITS;
   localparam int unsigned ADJ_DEPTH     = NUM_VERTS * NUM_SLOTS;
   localparam int unsigned STACK_DEPTH   = 64;
   localparam int unsigned STACK_BITS    = 6;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [VERT_BITS-1:0]   vertex;
      logic [SLOT_BITS-1:0]   slot;
      logic [VERT_BITS-1:0]   neighbor;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   enabled;
      logic [VERT_BITS-1:0]   start_vertex;
      logic [VERT_BITS-1:0]   end_vertex;
   } req_type;

   typedef struct packed {
      logic [VERT_BITS-1:0] path_from;
      logic [VERT_BITS-1:0] path_to;
      logic [SLOT_BITS-1:0] path_slot;
      logic                 found;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                   enabled;
      logic [VERT_BITS-1:0]   neighbor;
      logic [WEIGHT_BITS-1:0] weight;
   } adj_entry_type;

   typedef struct packed {
      logic                     en;
      logic [ADJ_ADDR_BITS-1:0] addr;
      adj_entry_type            data;
   } adj_wr_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] cost;
      logic [VERT_BITS-1:0] pred_vertex;
      logic [SLOT_BITS-1:0] pred_slot;
   } vert_entry_type;

   typedef struct packed {
      logic [VERT_BITS-1:0] from_v;
      logic [VERT_BITS-1:0] to_v;
      logic [SLOT_BITS-1:0] slot;
   } stack_entry_type;

endpackage

// ----- rtl/spath_adj_ram.sv -----
// Adjacency slot memory with a clearing sweep after reset.
module spath_adj_ram (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spath_pkg::adj_wr_type                wr,
   input  logic [spath_pkg::ADJ_ADDR_BITS-1:0]  rd_addr,
   output spath_pkg::adj_entry_type             rd_data,
   output logic                                 busy
);

   spath_pkg::adj_entry_type mem [spath_pkg::ADJ_DEPTH];
   spath_pkg::adj_entry_type rd_data_ff;
   logic [spath_pkg::ADJ_ADDR_BITS:0] clr_cnt_ff;
   logic [spath_pkg::ADJ_ADDR_BITS:0] clr_cnt_in;

   assign busy       = !clr_cnt_ff[spath_pkg::ADJ_ADDR_BITS];
   assign clr_cnt_in = busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // clear one slot a cycle until the sweep ends, then take loads
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_cnt_ff[spath_pkg::ADJ_ADDR_BITS-1:0]] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/spath_rsp_reg.sv -----
// Output register of the result channel.
module spath_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  spath_pkg::rsp_type push_data,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spath_pkg::rsp_type rsp_data
);

   logic               vld_ff;
   logic               vld_in;
   spath_pkg::rsp_type data_ff;

   assign free      = !vld_ff || !rsp_stall;
   assign vld_in    = push || (vld_ff && rsp_stall);
   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule

// ----- rtl/shortest_path_search_core.sv -----
// Top level of the shortest path search core.
//
// Requests arrive on req_ (valid/stall). A load request writes one neighbour
// slot (neighbour, weight, enabled) of one vertex and produces no result.
// A query request searches the shortest path from start_vertex to
// end_vertex over enabled slots and returns its edges on rsp_, start first,
// the final one marked last. Unreachable end: one result, found clear.
// Start equal to end: one result, found clear, from = to = start.
// A load leaves the core idle and ready for the next request. A query
// repeats a linear scan of the vertex memory for the next vertex to settle,
// then reads each slot of that vertex and relaxes its enabled ones; at the
// end it walks the path back and replays it. The search time is set by
// the linear scan over the vertex memory, which has one read port, and by
// the single adjacency read per slot.
// After reset the adjacency memory is swept clear with req_stall high.
// A stalled result waits in the output register; the search holds until
// it is taken, but after the final result the next request is accepted
// at once.
module shortest_path_search_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  spath_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spath_pkg::rsp_type rsp_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ONE   = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_R_ADJ = 4'd3;
   localparam logic [3:0] ST_R_VRD = 4'd4;
   localparam logic [3:0] ST_R_UPD = 4'd5;
   localparam logic [3:0] ST_B_RD  = 4'd6;
   localparam logic [3:0] ST_B_WR  = 4'd7;
   localparam logic [3:0] ST_E_RD  = 4'd8;
   localparam logic [3:0] ST_E_OUT = 4'd9;

   localparam int unsigned VB = spath_pkg::VERT_BITS;
   localparam int unsigned SB = spath_pkg::SLOT_BITS;
   localparam int unsigned DB = spath_pkg::DIST_BITS;
   localparam int unsigned NV = spath_pkg::NUM_VERTS;

   // control
   logic [3:0]    state_ff, state_in;
   logic [VB-1:0] start_ff, start_in;
   logic [VB-1:0] end_ff, end_in;
   logic [NV-1:0] reached_ff, reached_in;
   logic [NV-1:0] settled_ff, settled_in;
   logic [VB:0]   scan_cnt_ff, scan_cnt_in;
   logic          pipe_vld_ff, pipe_vld_in;
   logic          pipe_cand_ff, pipe_cand_in;
   logic [VB-1:0] pipe_idx_ff, pipe_idx_in;
   logic          any_ff, any_in;
   logic [VB-1:0] best_idx_ff, best_idx_in;
   logic [DB-1:0] best_dist_ff, best_dist_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [VB-1:0] cur_ff, cur_in;
   logic [spath_pkg::STACK_BITS:0] depth_ff, depth_in;
   spath_pkg::adj_entry_type adj_q_ff, adj_q_in;
   spath_pkg::rsp_type       one_res_ff, one_res_in;

   // memories
   spath_pkg::vert_entry_type  vmem [NV];
   spath_pkg::vert_entry_type  vrd_ff;
   spath_pkg::stack_entry_type smem [spath_pkg::STACK_DEPTH];
   spath_pkg::stack_entry_type srd_ff;

   logic                            vwr_en;
   logic [VB-1:0]                   vwr_addr;
   spath_pkg::vert_entry_type       vwr_data;
   logic [VB-1:0]                   vrd_addr;
   logic                            swr_en;
   logic [spath_pkg::STACK_BITS-1:0] swr_addr;
   spath_pkg::stack_entry_type      swr_data;
   logic                            srd_en;
   logic [spath_pkg::STACK_BITS-1:0] srd_addr;

   spath_pkg::adj_wr_type                adj_wr;
   logic [spath_pkg::ADJ_ADDR_BITS-1:0]  adj_rd_addr;
   spath_pkg::adj_entry_type             adj_rd_data;
   logic                                 adj_busy;

   logic               push;
   spath_pkg::rsp_type push_data;
   logic               rsp_free;
   logic [DB-1:0]      cand_cost;

   spath_adj_ram u_adj (
      .clock   (clock),
      .reset   (reset),
      .wr      (adj_wr),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data),
      .busy    (adj_busy)
   );

   spath_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign cand_cost = best_dist_ff + DB'(adj_q_ff.weight);

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      reached_in   = reached_ff;
      settled_in   = settled_ff;
      scan_cnt_in  = scan_cnt_ff;
      pipe_vld_in  = pipe_vld_ff;
      pipe_cand_in = pipe_cand_ff;
      pipe_idx_in  = pipe_idx_ff;
      any_in       = any_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      adj_q_in     = adj_q_ff;
      one_res_in   = one_res_ff;
      vwr_en       = 1'b0;
      vwr_addr     = best_idx_ff;
      vwr_data     = '0;
      vrd_addr     = scan_cnt_ff[VB-1:0];
      swr_en       = 1'b0;
      swr_addr     = depth_ff[spath_pkg::STACK_BITS-1:0];
      swr_data     = '0;
      srd_en       = 1'b0;
      srd_addr     = depth_ff[spath_pkg::STACK_BITS-1:0];
      adj_wr       = '0;
      adj_rd_addr  = {best_idx_ff, slot_ff};
      push         = 1'b0;
      push_data    = one_res_ff;
      req_stall    = (state_ff != ST_IDLE) || adj_busy;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               if (req_data.operation == spath_pkg::OP_LOAD) begin
                  adj_wr.en   = 1'b1;
                  adj_wr.addr = {req_data.vertex, req_data.slot};
                  adj_wr.data = '{enabled:  req_data.enabled,
                                  neighbor: req_data.neighbor,
                                  weight:   req_data.weight};
               end else begin
                  start_in = req_data.start_vertex;
                  end_in   = req_data.end_vertex;
                  if (req_data.start_vertex == req_data.end_vertex) begin
                     // empty path: report the start alone
                     one_res_in = '{path_from: req_data.start_vertex,
                                    path_to:   req_data.start_vertex,
                                    path_slot: '0, found: 1'b0, last: 1'b1};
                     state_in   = ST_ONE;
                  end else begin
                     reached_in  = NV'(1) << req_data.start_vertex;
                     settled_in  = '0;
                     vwr_en      = 1'b1;
                     vwr_addr    = req_data.start_vertex;
                     scan_cnt_in = '0;
                     pipe_vld_in = 1'b0;
                     any_in      = 1'b0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         ST_ONE: begin
            if (rsp_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // issue one vertex read a cycle, compare the one read last cycle
            pipe_vld_in = 1'b0;
            if (!scan_cnt_ff[VB]) begin
               vrd_addr     = scan_cnt_ff[VB-1:0];
               pipe_vld_in  = 1'b1;
               pipe_idx_in  = scan_cnt_ff[VB-1:0];
               pipe_cand_in = reached_ff[scan_cnt_ff[VB-1:0]] &&
                              !settled_ff[scan_cnt_ff[VB-1:0]];
               scan_cnt_in  = scan_cnt_ff + 1'b1;
            end
            if (pipe_vld_ff && pipe_cand_ff && (!any_ff || vrd_ff.cost < best_dist_ff)) begin
               any_in       = 1'b1;
               best_idx_in  = pipe_idx_ff;
               best_dist_in = vrd_ff.cost;
            end
            if (scan_cnt_ff[VB] && !pipe_vld_ff) begin
               if (!any_ff) begin
                  one_res_in = '{path_from: '0, path_to: '0, path_slot: '0,
                                 found: 1'b0, last: 1'b1};
                  state_in   = ST_ONE;
               end else begin
                  settled_in[best_idx_ff] = 1'b1;
                  if (best_idx_ff == end_ff) begin
                     cur_in   = end_ff;
                     depth_in = '0;
                     state_in = ST_B_RD;
                  end else begin
                     slot_in  = '0;
                     state_in = ST_R_ADJ;
                  end
               end
            end
         end
         ST_R_ADJ: begin
            adj_rd_addr = {best_idx_ff, slot_ff};
            state_in    = ST_R_VRD;
         end
         ST_R_VRD: begin
            adj_q_in = adj_rd_data;
            vrd_addr = adj_rd_data.neighbor;
            if (adj_rd_data.enabled) begin
               state_in = ST_R_UPD;
            end else if (slot_ff == SB'(spath_pkg::NUM_SLOTS - 1)) begin
               scan_cnt_in = '0;
               any_in      = 1'b0;
               pipe_vld_in = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_R_ADJ;
            end
         end
         ST_R_UPD: begin
            // relax only on a strictly shorter distance
            if (!reached_ff[adj_q_ff.neighbor] || cand_cost < vrd_ff.cost) begin
               vwr_en   = 1'b1;
               vwr_addr = adj_q_ff.neighbor;
               vwr_data = '{cost: cand_cost, pred_vertex: best_idx_ff,
                            pred_slot: slot_ff};
               reached_in[adj_q_ff.neighbor] = 1'b1;
            end
            if (slot_ff == SB'(spath_pkg::NUM_SLOTS - 1)) begin
               scan_cnt_in = '0;
               any_in      = 1'b0;
               pipe_vld_in = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_R_ADJ;
            end
         end
         ST_B_RD: begin
            vrd_addr = cur_ff;
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            // push the edge into cur, walk back to its predecessor
            swr_en   = 1'b1;
            swr_addr = depth_ff[spath_pkg::STACK_BITS-1:0];
            swr_data = '{from_v: vrd_ff.pred_vertex, to_v: cur_ff,
                         slot: vrd_ff.pred_slot};
            depth_in = depth_ff + 1'b1;
            cur_in   = vrd_ff.pred_vertex;
            state_in = (vrd_ff.pred_vertex == start_ff) ? ST_E_RD : ST_B_RD;
         end
         ST_E_RD: begin
            srd_en   = 1'b1;
            srd_addr = spath_pkg::STACK_BITS'(depth_ff - 1'b1);
            depth_in = depth_ff - 1'b1;
            state_in = ST_E_OUT;
         end
         ST_E_OUT: begin
            push_data = '{path_from: srd_ff.from_v, path_to: srd_ff.to_v,
                          path_slot: srd_ff.slot, found: 1'b1,
                          last: (depth_ff == '0)};
            if (rsp_free) begin
               push     = 1'b1;
               state_in = (depth_ff == '0) ? ST_IDLE : ST_E_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      end_ff       <= end_in;
      reached_ff   <= reached_in;
      settled_ff   <= settled_in;
      scan_cnt_ff  <= scan_cnt_in;
      pipe_vld_ff  <= pipe_vld_in;
      pipe_cand_ff <= pipe_cand_in;
      pipe_idx_ff  <= pipe_idx_in;
      any_ff       <= any_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      slot_ff      <= slot_in;
      cur_ff       <= cur_in;
      depth_ff     <= depth_in;
      adj_q_ff     <= adj_q_in;
      one_res_ff   <= one_res_in;
   end

   // vertex memory: distance and predecessor per vertex
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         vmem[vwr_addr] <= vwr_data;
      end
      vrd_ff <= vmem[vrd_addr];
   end

   // path stack: edges pushed end first, popped start first
   always_ff @(posedge clock) begin
      if (swr_en) begin
         smem[swr_addr] <= swr_data;
      end
      if (srd_en) begin
         srd_ff <= smem[srd_addr];
      end
   end

endmodule

// ----- rtl/spath_checker.sv -----
// Port checker of the shortest path search core and its bind.
module spath_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input spath_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input spath_pkg::rsp_type rsp_data
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // the clearing sweep holds requests off after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing sweep");

   // an accepted query makes the block go busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == spath_pkg::OP_QUERY
      |=> req_stall)
      else $error("query accepted without going busy");

   // a result without a path edge ends its query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found || rsp_data.last))
      else $error("empty result not marked last");

endmodule

bind shortest_path_search_core spath_checker u_spath_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
